FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold at every clock edge out of reset.
`define GBN_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

FILE: src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Operation codes, command and result flag types, and default sizes.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Default sizes for the top level parameters and the depth of both queues.
    localparam int SEQ_MOD_DEF      = 8;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;

    // Operation codes seen on the input port.
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_ACK,
        CMD_TIMEOUT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      intact;
    } cmd_ctrl_t;

    typedef struct packed {
        logic packet_valid;
        logic timer_start;
        logic timer_stop;
        logic send_accepted;
        logic ack_accepted;
        logic last;
    } res_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

FILE: src/gbn_queue.sv
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer of DEPTH entries with push/full and pop/empty.
// ----------------------------------------------------------------------------
module gbn_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = gbn_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/gbn_front.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender front end
// Takes input transactions, decodes the operation, works out the new window
// base of an acknowledgement and queues a command for the back end.
// ----------------------------------------------------------------------------
module gbn_front #(
    parameter int SEQ_MOD      = gbn_pkg::SEQ_MOD_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF,
    parameter int PTR_W        = $clog2(SEQ_MOD)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              operation,
    input  logic [63:0]             payload,
    input  logic signed [3:0]       ack_number,
    input  logic                    ack_intact,
    output logic                    cmd_valid,
    input  logic                    cmd_pop,
    output gbn_pkg::cmd_ctrl_t      cmd_ctrl,
    output logic [PTR_W-1:0]        cmd_base,
    output logic [PAYLOAD_BITS-1:0] cmd_payload
);

    // Reduction of ack_number + 1 into 0 .. SEQ_MOD-1. A multiple of SEQ_MOD
    // of at least seven is added first so that the sum is never negative.
    localparam int OFFSET    = SEQ_MOD * ((7 + SEQ_MOD - 1) / SEQ_MOD);
    localparam int RED_W     = $clog2(SEQ_MOD + 15) + 1;
    localparam int RED_STEPS = (14 + SEQ_MOD) / SEQ_MOD;
    localparam int CTRL_W    = $bits(gbn_pkg::cmd_ctrl_t);
    localparam int CMD_W     = CTRL_W + PTR_W + PAYLOAD_BITS;

    gbn_pkg::cmd_ctrl_t  ctrl_in;
    logic [RED_W-1:0]    base_sum;
    logic [PTR_W-1:0]    base_in;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic [CMD_W-1:0]    q_wdata;
    logic [CMD_W-1:0]    q_rdata;

    always_comb
    begin
        ctrl_in.intact = ack_intact;
        case (operation)
            gbn_pkg::OP_SEND:    ctrl_in.kind = gbn_pkg::CMD_SEND;
            gbn_pkg::OP_ACK:     ctrl_in.kind = gbn_pkg::CMD_ACK;
            gbn_pkg::OP_TIMEOUT: ctrl_in.kind = gbn_pkg::CMD_TIMEOUT;
            default:             ctrl_in.kind = gbn_pkg::CMD_SEND;
        endcase
    end

    always_comb
    begin
        base_sum = RED_W'(OFFSET + 1) + {{(RED_W - 4){ack_number[3]}}, ack_number};
        for (int k = 0; k < RED_STEPS; k++)
        begin
            if (base_sum >= RED_W'(SEQ_MOD))
            begin
                base_sum = base_sum - RED_W'(SEQ_MOD);
            end
        end
        base_in = base_sum[PTR_W-1:0];
    end

    // The unused operation code is taken and dropped here.
    assign full    = q_full;
    assign q_push  = push && !q_full && (operation != gbn_pkg::OP_UNUSED);
    assign q_wdata = {ctrl_in, base_in, payload[PAYLOAD_BITS-1:0]};

    gbn_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (gbn_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_valid   = !q_empty;
    assign cmd_ctrl    = gbn_pkg::cmd_ctrl_t'(q_rdata[CMD_W-1 -: CTRL_W]);
    assign cmd_base    = q_rdata[PAYLOAD_BITS +: PTR_W];
    assign cmd_payload = q_rdata[PAYLOAD_BITS-1:0];

endmodule

FILE: src/gbn_back.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender back end
// Holds the window pointers and the packet store, carries out queued commands
// and walks the window on a timeout, reading and then emitting each stored packet.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbn_back #(
    parameter int SEQ_MOD      = gbn_pkg::SEQ_MOD_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF,
    parameter int PTR_W        = $clog2(SEQ_MOD)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_pop,
    input  gbn_pkg::cmd_ctrl_t      cmd_ctrl,
    input  logic [PTR_W-1:0]        cmd_base,
    input  logic [PAYLOAD_BITS-1:0] cmd_payload,
    input  logic                    res_full,
    output logic                    res_push,
    output gbn_pkg::res_flags_t     res_flags,
    output logic [2:0]              res_seq,
    output logic [PAYLOAD_BITS-1:0] res_data
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SEQ_MOD - 1);
    localparam int               SEQ_EXT_W = (PTR_W > 3) ? PTR_W : 3;
    localparam logic [PTR_W:0]   SEQ_MOD_P = (PTR_W + 1)'(SEQ_MOD);

    gbn_pkg::state_t         state_reg, state_next;
    logic [PTR_W-1:0]        base_reg, base_next;
    logic [PTR_W-1:0]        next_reg, next_next;
    logic [PTR_W-1:0]        idx_reg, idx_next;
    logic                    first_reg, first_next;
    logic [PAYLOAD_BITS-1:0] store [SEQ_MOD];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;
    logic                    mem_we;
    logic [PTR_W-1:0]        next_inc;
    logic [PTR_W-1:0]        idx_inc;
    logic [PTR_W-1:0]        seq_ptr;
    logic [SEQ_EXT_W-1:0]    seq_ext;

    assign next_inc = (next_reg == LAST_PTR) ? '0 : next_reg + 1'b1;
    assign idx_inc  = (idx_reg == LAST_PTR) ? '0 : idx_reg + 1'b1;
    assign seq_ext  = SEQ_EXT_W'(seq_ptr);
    assign res_seq  = seq_ext[2:0];

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_flags  = '0;
        seq_ptr    = '0;
        res_data   = '0;
        mem_we     = 1'b0;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_ctrl.kind)
                        gbn_pkg::CMD_SEND:
                        begin
                            res_push       = 1'b1;
                            res_flags.last = 1'b1;
                            if (next_inc != base_reg)
                            begin
                                mem_we                  = 1'b1;
                                res_flags.packet_valid  = 1'b1;
                                res_flags.timer_start   = (base_reg == next_reg);
                                res_flags.send_accepted = 1'b1;
                                seq_ptr                 = next_reg;
                                res_data                = cmd_payload;
                                next_next               = next_inc;
                            end
                        end
                        gbn_pkg::CMD_ACK:
                        begin
                            res_push       = 1'b1;
                            res_flags.last = 1'b1;
                            if (cmd_ctrl.intact)
                            begin
                                base_next              = cmd_base;
                                res_flags.timer_stop   = 1'b1;
                                res_flags.timer_start  = (cmd_base != next_reg);
                                res_flags.ack_accepted = 1'b1;
                            end
                        end
                        gbn_pkg::CMD_TIMEOUT:
                        begin
                            if (base_reg == next_reg)
                            begin
                                res_push              = 1'b1;
                                res_flags.timer_stop  = 1'b1;
                                res_flags.timer_start = 1'b1;
                                res_flags.last        = 1'b1;
                            end
                            else
                            begin
                                idx_next   = base_reg;
                                first_next = 1'b1;
                                state_next = gbn_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            gbn_pkg::ST_READ:
            begin
                state_next = gbn_pkg::ST_EMIT;
            end
            gbn_pkg::ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push               = 1'b1;
                    res_flags.packet_valid = 1'b1;
                    res_flags.timer_start  = first_reg;
                    res_flags.timer_stop   = first_reg;
                    res_flags.last         = (idx_inc == next_reg);
                    seq_ptr                = idx_reg;
                    res_data               = rd_data_reg;
                    first_next             = 1'b0;
                    idx_next               = idx_inc;
                    state_next = (idx_inc == next_reg) ? gbn_pkg::ST_IDLE : gbn_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
            base_reg  <= '0;
            next_reg  <= '0;
            idx_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            idx_reg   <= idx_next;
            first_reg <= first_next;
        end
    end

    // Packet store: written by a send, read during a window walk.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[next_reg] <= cmd_payload;
        end
        rd_data_reg <= store[idx_reg];
    end

    `GBN_ASSERT_IMP(a_no_push_when_full, res_push, !res_full, "result written into a full queue")
    `GBN_ASSERT_NEXT(a_window_held_in_walk, state_reg != gbn_pkg::ST_IDLE, $stable(base_reg) && $stable(next_reg), "window moved during a resend walk")
    `GBN_ASSERT_ALWAYS(a_pointers_in_range, ((PTR_W + 1)'(base_reg) < SEQ_MOD_P) && ((PTR_W + 1)'(next_reg) < SEQ_MOD_P), "window pointer beyond the sequence range")
    `GBN_ASSERT_NEXT(a_walk_ends_idle, (state_reg == gbn_pkg::ST_EMIT) && res_push && res_flags.last, state_reg == gbn_pkg::ST_IDLE, "resend walk did not finish on its last packet")

endmodule

FILE: src/go_back_n_sender_window_unit.sv
// Sends and acknowledgements pass the command queue, then the back end, then the result queue.
// Throughput: one send or acknowledgement per cycle while results drain and no walk runs.
// A timeout with outstanding packets holds the back end: it takes the command, then for each
// packet does a registered store read and an emit, which waits while the result queue is full.
// Reset clears both window pointers and empties both queues; the store is not cleared.
// ----------------------------------------------------------------------------
// Go-Back-N sender window unit
// Sender side of a Go-Back-N ARQ link: stores sent packets in a ring, tracks
// the window and replays it on a retransmission timeout.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit #(
    parameter int SEQ_MOD      = gbn_pkg::SEQ_MOD_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // Input transactions
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [63:0]       payload,
    input  logic signed [3:0] ack_number,
    input  logic              ack_intact,
    // Result transactions
    output logic              empty,
    input  logic              pop,
    output logic              packet_valid,
    output logic [2:0]        seq_number,
    output logic [63:0]       packet_data,
    output logic              timer_start,
    output logic              timer_stop,
    output logic              send_accepted,
    output logic              ack_accepted,
    output logic              last
);

    // Pointer width follows from the sequence space.
    localparam int PTR_W   = $clog2(SEQ_MOD);
    localparam int FLAGS_W = $bits(gbn_pkg::res_flags_t);
    localparam int RES_W   = FLAGS_W + 3 + PAYLOAD_BITS;

    // The front end decodes each transaction and parks all but the unused operation
    // in a short command queue, so the input side keeps accepting until that queue
    // is full while the back end is busy replaying the window after a timeout.
    logic                    cmd_valid;
    logic                    cmd_pop;
    gbn_pkg::cmd_ctrl_t      cmd_ctrl;
    logic [PTR_W-1:0]        cmd_base;
    logic [PAYLOAD_BITS-1:0] cmd_payload;

    // Results leave the back end through a second queue, which decouples the
    // back end from a consumer that holds pop low.
    logic                    res_full;
    logic                    res_push;
    gbn_pkg::res_flags_t     res_flags;
    logic [2:0]              res_seq;
    logic [PAYLOAD_BITS-1:0] res_data;
    logic [RES_W-1:0]        res_wdata;
    logic [RES_W-1:0]        res_rdata;
    gbn_pkg::res_flags_t     out_flags;

    gbn_front #(
        .SEQ_MOD      (SEQ_MOD),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PTR_W        (PTR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .payload     (payload),
        .ack_number  (ack_number),
        .ack_intact  (ack_intact),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_ctrl    (cmd_ctrl),
        .cmd_base    (cmd_base),
        .cmd_payload (cmd_payload)
    );

    // The back end owns the window base, the next sequence number and the
    // packet store. A send or acknowledgement is completed in the cycle it is
    // popped; a timeout on a non-empty window walks from the base to the next
    // sequence number, reading each stored packet and then emitting it.
    gbn_back #(
        .SEQ_MOD      (SEQ_MOD),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PTR_W        (PTR_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_ctrl    (cmd_ctrl),
        .cmd_base    (cmd_base),
        .cmd_payload (cmd_payload),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_flags   (res_flags),
        .res_seq     (res_seq),
        .res_data    (res_data)
    );

    assign res_wdata = {res_flags, res_seq, res_data};

    gbn_queue #(
        .DATA_W (RES_W),
        .DEPTH  (gbn_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Unpack the oldest waiting result onto the output ports. The stored
    // payload is narrower than the port when PAYLOAD_BITS is below 64, so it
    // is zero-extended here.
    assign out_flags     = gbn_pkg::res_flags_t'(res_rdata[RES_W-1 -: FLAGS_W]);
    assign seq_number    = res_rdata[PAYLOAD_BITS +: 3];
    assign packet_data   = 64'(res_rdata[PAYLOAD_BITS-1:0]);
    assign packet_valid  = out_flags.packet_valid;
    assign timer_start   = out_flags.timer_start;
    assign timer_stop    = out_flags.timer_stop;
    assign send_accepted = out_flags.send_accepted;
    assign ack_accepted  = out_flags.ack_accepted;
    assign last          = out_flags.last;

endmodule
